@@ hdl/fit_policy_block_allocator_unit_assert.svh @@
// assertion macros for the block allocator
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during reset
`define FPBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ hdl/fpba_pkg.sv @@
`default_nettype none

package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int AMOUNT_W   = 16;
    localparam int INDEX_W    = 4;
    localparam int FRAG_W     = 20;
    localparam int COUNT_W    = 16;
    localparam int POLICY_W   = 2;
    localparam int BCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [FRAG_W-1:0]  FRAG_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 5'd16;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_WORST = 2'd1,
        POL_BEST  = 2'd2
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_SCAN,
        ST_ADJ_SUB,
        ST_ADJ_ADD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] load_index;
        logic [AMOUNT_W-1:0] amount;
    } item_t;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] chosen_block;
        logic [FRAG_W-1:0]  fragmentation;
        logic [COUNT_W-1:0] unplaced_count;
    } result_t;

    typedef struct packed {
        logic                clear;
        logic                sample;
        logic                sub_old;
        logic                add_new;
        logic [POLICY_W-1:0] policy;
    } scan_ctl_t;

    typedef struct packed {
        logic load_wr;
        logic alloc_wr;
        logic finish;
        logic alloc;
    } seq_t;

    function automatic int addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fpba_mem.sv @@
`default_nettype none

module fpba_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/fpba_scan.sv @@
`default_nettype none

module fpba_scan #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire fpba_pkg::scan_ctl_t                   ctl,
    input  wire logic [SIZE_BITS-1:0]                  amt,
    input  wire logic [2*SIZE_BITS-1:0]                rd_data,
    output logic                                       found,
    output logic [fpba_pkg::addr_bits(NUM_BLOCKS)-1:0] pick,
    output logic [2*SIZE_BITS-1:0]                     wr_data,
    output logic [fpba_pkg::FRAG_W-1:0]                frag
);

    import fpba_pkg::*;

    localparam int AW    = addr_bits(NUM_BLOCKS);
    localparam int CW    = $clog2(NUM_BLOCKS + 1);
    localparam int ACC_W = SIZE_BITS + CW;
    localparam int CLW   = (ACC_W > FRAG_W) ? ACC_W : FRAG_W;

    logic                 found_reg,     found_next;
    logic [CW-1:0]        idx_reg,       idx_next;
    logic [AW-1:0]        pick_reg,      pick_next;
    logic [SIZE_BITS-1:0] best_free_reg, best_free_next;
    logic [SIZE_BITS-1:0] best_used_reg, best_used_next;
    logic [ACC_W-1:0]     acc_reg,       acc_next;

    logic [SIZE_BITS-1:0] ent_free;
    logic [SIZE_BITS-1:0] ent_used;
    logic [SIZE_BITS-1:0] new_free;
    logic [SIZE_BITS-1:0] new_used;
    logic [SIZE_BITS-1:0] operand;
    logic                 better;
    logic                 take;
    logic [CLW-1:0]       acc_wide;

    assign ent_free = rd_data[SIZE_BITS-1:0];
    assign ent_used = rd_data[2*SIZE_BITS-1:SIZE_BITS];
    assign new_free = best_free_reg - amt;
    assign new_used = best_used_reg + amt;

    // policy compare against the current pick
    always_comb
    begin
        case (ctl.policy)
            POL_WORST: better = ent_free > best_free_reg;
            POL_BEST:  better = ent_free < best_free_reg;
            default:   better = 1'b0;
        endcase
    end

    assign take = ctl.sample && (ent_free >= amt) && (!found_reg || better);

    // shared accumulator operand
    always_comb
    begin
        operand = '0;
        if (ctl.sample)
        begin
            operand = (ent_used != '0) ? ent_free : '0;
        end
        else if (ctl.sub_old)
        begin
            operand = (best_used_reg != '0) ? best_free_reg : '0;
        end
        else if (ctl.add_new)
        begin
            operand = (new_used != '0) ? new_free : '0;
        end
    end

    always_comb
    begin
        found_next     = found_reg;
        idx_next       = idx_reg;
        pick_next      = pick_reg;
        best_free_next = best_free_reg;
        best_used_next = best_used_reg;
        acc_next       = acc_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
            idx_next   = '0;
            acc_next   = '0;
        end
        else if (ctl.sample)
        begin
            idx_next = idx_reg + 1'b1;
            acc_next = acc_reg + ACC_W'(operand);
            if (take)
            begin
                found_next     = 1'b1;
                pick_next      = idx_reg[AW-1:0];
                best_free_next = ent_free;
                best_used_next = ent_used;
            end
        end
        else if (ctl.sub_old)
        begin
            acc_next = acc_reg - ACC_W'(operand);
        end
        else if (ctl.add_new)
        begin
            acc_next = acc_reg + ACC_W'(operand);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            found_reg <= found_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg      <= pick_next;
        best_free_reg <= best_free_next;
        best_used_reg <= best_used_next;
        acc_reg       <= acc_next;
    end

    assign acc_wide = CLW'(acc_reg);

    assign found   = found_reg;
    assign pick    = pick_reg;
    assign wr_data = {new_used, new_free};
    assign frag    = (acc_wide > CLW'(FRAG_MAX)) ? FRAG_MAX : acc_wide[FRAG_W-1:0];

endmodule

`default_nettype wire

@@ hdl/fpba_ctrl.sv @@
`default_nettype none
`include "fit_policy_block_allocator_unit_assert.svh"

module fpba_ctrl #(
    parameter int NUM_BLOCKS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  op_in,
    input  wire logic                                  found,
    input  wire logic [fpba_pkg::POLICY_W-1:0]         policy,
    input  wire logic [fpba_pkg::BCOUNT_W-1:0]         block_count,
    output logic                                       busy,
    output logic                                       rd_en,
    output logic [fpba_pkg::addr_bits(NUM_BLOCKS)-1:0] rd_addr,
    output fpba_pkg::scan_ctl_t                        scan_ctl,
    output fpba_pkg::seq_t                             seq
);

    import fpba_pkg::*;

    localparam int AW = addr_bits(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          op_reg,    op_next;
    logic          rd_pending_reg;
    logic [CW-1:0] n_eff;

    assign n_eff = (32'(block_count) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(block_count);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (op_in == OP_LOAD) ? ST_LOAD_WR : ST_SCAN;
                end
            end
            ST_LOAD_WR: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (cnt_reg == n_eff)
                begin
                    state_next = (op_reg == OP_ALLOC) ? ST_ADJ_SUB : ST_FINISH;
                end
            end
            ST_ADJ_SUB: state_next = ST_ADJ_ADD;
            ST_ADJ_ADD: state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = 1'b1;
        rd_en    = 1'b0;
        cnt_next = cnt_reg;
        op_next  = op_reg;
        seq      = '0;
        scan_ctl = '0;
        scan_ctl.policy = policy;
        scan_ctl.sample = rd_pending_reg;
        seq.alloc       = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cnt_next = '0;
                if (start)
                begin
                    op_next        = op_in;
                    scan_ctl.clear = 1'b1;
                end
            end
            ST_LOAD_WR: seq.load_wr = 1'b1;
            ST_SCAN:
            begin
                if (cnt_reg != n_eff)
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ADJ_SUB:
            begin
                scan_ctl.sub_old = found;
                seq.alloc_wr     = found;
            end
            ST_ADJ_ADD: scan_ctl.add_new = found;
            ST_FINISH:  seq.finish = 1'b1;
            default:    busy = 1'b1;
        endcase
    end

    assign rd_addr = cnt_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            op_reg         <= OP_LOAD;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            op_reg         <= op_next;
            rd_pending_reg <= rd_en;
        end
    end

    `FPBA_ASSERT_NOW(a_rd_in_range, rd_en, cnt_reg < n_eff)
    `FPBA_ASSERT_NEXT(a_accept_busy, start && state_reg == ST_IDLE, state_reg != ST_IDLE)
    `FPBA_ASSERT_NOW(a_adj_alloc_only, state_reg == ST_ADJ_SUB, op_reg == OP_ALLOC)
    `FPBA_ASSERT_NOW(a_idle_drained, state_reg == ST_IDLE, !rd_pending_reg)

endmodule

`default_nettype wire

@@ hdl/fit_policy_block_allocator_unit.sv @@
// an allocate runs the scan of n entries, a subtract, an add and a finish step; n = blocks in use
// a load writes its entry first, then scans and finishes; no new start is taken while busy
// the next start is taken in the strobe cycle
// the single compare/accumulate unit visits one block table entry per cycle
// results are strobed for one cycle; the receiver cannot stall
// reset: first fit, 16 blocks, unplaced counter zero; block table is not cleared
`default_nettype none

module fit_policy_block_allocator_unit #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire fpba_pkg::item_t                 item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                 result_valid,
    output fpba_pkg::result_t                    result
);

    import fpba_pkg::*;

    localparam int AW = addr_bits(NUM_BLOCKS);
    localparam int DW = 2 * SIZE_BITS;

    logic [POLICY_W-1:0]  policy_reg;
    logic [BCOUNT_W-1:0]  bcount_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [SIZE_BITS-1:0] amt_reg;
    logic [COUNT_W-1:0]   unplaced_reg, unplaced_next;
    logic                 result_valid_reg;
    result_t              result_reg, result_next;

    scan_ctl_t            scan_ctl;
    seq_t                 seq;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [DW-1:0]        rd_data;
    logic                 found;
    logic [AW-1:0]        pick;
    logic [DW-1:0]        scan_wdata;
    logic [FRAG_W-1:0]    frag;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DW-1:0]        mem_wdata;
    logic                 idx_ok;
    logic                 granted;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            bcount_reg <= BCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:  policy_reg <= cfg_data[POLICY_W-1:0];
                CFG_BLOCK_COUNT: bcount_reg <= cfg_data[BCOUNT_W-1:0];
                default:         policy_reg <= policy_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            idx_reg <= item.load_index;
            amt_reg <= SIZE_BITS'(item.amount);
        end
    end

    fpba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op_in       (item.op),
        .found       (found),
        .policy      (policy_reg),
        .block_count (bcount_reg),
        .busy        (busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .scan_ctl    (scan_ctl),
        .seq         (seq)
    );

    fpba_scan #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .amt     (amt_reg),
        .rd_data (rd_data),
        .found   (found),
        .pick    (pick),
        .wr_data (scan_wdata),
        .frag    (frag)
    );

    assign idx_ok    = 32'(idx_reg) < NUM_BLOCKS;
    assign mem_we    = (seq.load_wr && idx_ok) || seq.alloc_wr;
    assign mem_waddr = seq.load_wr ? AW'(idx_reg) : pick;
    assign mem_wdata = seq.load_wr ? {{SIZE_BITS{1'b0}}, amt_reg} : scan_wdata;

    fpba_mem #(
        .DEPTH (NUM_BLOCKS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign granted = (seq.alloc == OP_ALLOC) && found;

    always_comb
    begin
        unplaced_next = unplaced_reg;
        if (seq.finish && (seq.alloc == OP_ALLOC) && !found && (unplaced_reg != COUNT_MAX))
        begin
            unplaced_next = unplaced_reg + 1'b1;
        end
        result_next.granted        = granted;
        result_next.chosen_block   = granted ? INDEX_W'(pick) : '0;
        result_next.fragmentation  = frag;
        result_next.unplaced_count = unplaced_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unplaced_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            unplaced_reg     <= unplaced_next;
            result_valid_reg <= seq.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
